### hdl/stq_pkg.sv
//------------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted timer queue
// Field widths, operation and result codes, list cell slot and cell command.
//------------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int ID_W     = 4;
  localparam int IDS      = 16;
  localparam int EXP_W    = 64;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int TIMERS_D = 16;

  // input operations
  localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_REMOVE,
    CMD_INSERT,
    CMD_POP
  } cmd_t;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  owner;
    logic             valid;
  } slot_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] key;
  } cell_ctl_t;

  localparam slot_t SLOT_EMPTY = '0;

endpackage

`default_nettype wire

### hdl/stq_in_if.sv
//------------------------------------------------------------------------------
// stq_in_if: request channel of the sorted timer queue
// Valid/ready handshake carrying one request item.
//------------------------------------------------------------------------------
`default_nettype none

interface stq_in_if;
  logic                      valid;
  logic                      ready;
  logic [stq_pkg::OP_W-1:0]  operation;
  logic [stq_pkg::ID_W-1:0]  timer_id;
  logic [stq_pkg::EXP_W-1:0] expiry;
  logic [stq_pkg::EXP_W-1:0] now;

  modport source (output valid, output operation, output timer_id, output expiry,
                  output now, input ready);
  modport sink   (input valid, input operation, input timer_id, input expiry,
                  input now, output ready);
endinterface

`default_nettype wire

### hdl/stq_out_if.sv
//------------------------------------------------------------------------------
// stq_out_if: result channel of the sorted timer queue
// Valid/ready handshake carrying one result item.
//------------------------------------------------------------------------------
`default_nettype none

interface stq_out_if;
  logic                       valid;
  logic                       ready;
  logic [stq_pkg::KIND_W-1:0] kind;
  logic [stq_pkg::ID_W-1:0]   which_timer;
  logic                       pending;
  logic                       last;

  modport source (output valid, output kind, output which_timer, output pending,
                  output last, input ready);
  modport sink   (input valid, input kind, input which_timer, input pending,
                  input last, output ready);
endinterface

`default_nettype wire

### hdl/stq_cell.sv
//------------------------------------------------------------------------------
// stq_cell: one list position of the sorted timer queue
// Holds one slot; removes, pops or inserts by trading slots with its neighbors.
//------------------------------------------------------------------------------
`default_nettype none

module stq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::cell_ctl_t ctl,
  input  stq_pkg::slot_t     left_slot,
  input  logic               left_ins,
  input  stq_pkg::slot_t     right_slot,
  input  logic               chain_in,
  output stq_pkg::slot_t     slot,
  output logic               ins,
  output logic               chain_out
);
  import stq_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;
  logic  match;

  // a removal shifts this cell left once it or any cell before it matched
  assign match     = (ctl.cmd == CMD_REMOVE) && slot_r.valid && (slot_r.owner == ctl.id);
  assign chain_out = chain_in | match;
  // new entry goes behind every entry not later than it
  assign ins       = !slot_r.valid || (slot_r.expiry > ctl.key);
  assign slot      = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    unique case (ctl.cmd) inside
      CMD_REMOVE, CMD_POP: begin
        if (chain_out) slot_nxt = right_slot;
      end
      CMD_INSERT: begin
        if (left_ins) begin
          slot_nxt = left_slot;
        end else if (ins) begin
          slot_nxt.expiry = ctl.key;
          slot_nxt.owner  = ctl.id;
          slot_nxt.valid  = 1'b1;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r.expiry <= slot_nxt.expiry;
    slot_r.owner  <= slot_nxt.owner;
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

endmodule

`default_nettype wire

### hdl/sorted_timer_queue.sv
// Arm, delete and query give their single result in the cycle after accept.
// A query stays in idle; deleting an armed timer runs remove, a fresh arm insert;
//   re-arm of an armed timer runs remove, then insert, through the cell chain.
// Tick: the fire state pops due head entries until none is due, plus output stalls;
//   the chain pops one head entry per cycle while the result register is free.
// Reset: synchronous, active low; all timers disarmed and the list emptied at once.
//------------------------------------------------------------------------------
// sorted_timer_queue: timer list sorted by expiry
// Control sequencer, armed map and result register around a chain of list cells.
//------------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue #(
  parameter int TIMERS = stq_pkg::TIMERS_D
) (
  input  logic      clk,
  input  logic      rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);
  import stq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REMOVE = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_FIRE   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDS-1:0]    armed_map_r, armed_map_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [EXP_W-1:0]  key_r, key_nxt;
  logic              ins_ok_r, ins_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_which_r, out_which_nxt;
  logic              out_pend_r, out_pend_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  slot_t             slot_w  [TIMERS];
  logic              ins_w   [TIMERS];
  logic              chain_w [TIMERS+1];

  logic              out_free;
  logic              accept;
  logic              id_ok;
  logic              armed;
  logic              due0;
  logic              due1;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign id_ok       = {{(32-ID_W){1'b0}}, in_ch.timer_id} < 32'(TIMERS);
  assign armed       = id_ok && armed_map_r[in_ch.timer_id];
  // key_r holds the current time during a tick
  assign due0        = slot_w[0].valid && (slot_w[0].expiry <= key_r);
  assign due1        = slot_w[1].valid && (slot_w[1].expiry <= key_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.which_timer = out_which_r;
  assign out_ch.pending     = out_pend_r;
  assign out_ch.last        = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    armed_map_nxt = armed_map_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    ins_ok_nxt    = ins_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_which_nxt = out_which_r;
    out_pend_nxt  = out_pend_r;
    out_last_nxt  = out_last_r;
    ctl.cmd       = CMD_HOLD;
    ctl.id        = id_r;
    ctl.key       = key_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt        = in_ch.timer_id;
          out_valid_nxt = 1'b1;
          out_which_nxt = in_ch.timer_id;
          out_pend_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          unique case (in_ch.operation)
            OP_ARM: begin
              out_kind_nxt = KIND_ARM;
              out_pend_nxt = armed;
              key_nxt      = in_ch.expiry;
              // a full list takes no new timer unless it frees its own slot
              ins_ok_nxt   = id_ok && (armed || !slot_w[TIMERS-1].valid);
              if (armed) begin
                state_nxt = ST_REMOVE;
              end else if (id_ok && !slot_w[TIMERS-1].valid) begin
                state_nxt = ST_INSERT;
              end
            end
            OP_DELETE: begin
              out_kind_nxt = KIND_DELETE;
              ins_ok_nxt   = 1'b0;
              if (armed) state_nxt = ST_REMOVE;
            end
            OP_TICK: begin
              out_valid_nxt = out_valid_r && !out_ch.ready;
              key_nxt       = in_ch.now;
              state_nxt     = ST_FIRE;
            end
            OP_QUERY: begin
              out_kind_nxt = KIND_STATUS;
              out_pend_nxt = armed;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REMOVE: begin
        ctl.cmd              = CMD_REMOVE;
        armed_map_nxt[id_r]  = 1'b0;
        state_nxt            = ins_ok_r ? ST_INSERT : ST_IDLE;
      end
      ST_INSERT: begin
        ctl.cmd              = CMD_INSERT;
        armed_map_nxt[id_r]  = 1'b1;
        state_nxt            = ST_IDLE;
      end
      ST_FIRE: begin
        if (!due0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ctl.cmd                        = CMD_POP;
          armed_map_nxt[slot_w[0].owner] = 1'b0;
          out_valid_nxt                  = 1'b1;
          out_kind_nxt                   = KIND_FIRED;
          out_which_nxt                  = slot_w[0].owner;
          out_pend_nxt                   = 1'b0;
          out_last_nxt                   = !due1;
          if (!due1) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pop seeds the shift chain at the head
  assign chain_w[0] = (ctl.cmd == CMD_POP);

  for (genvar k = 0; k < TIMERS; k++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_ins;

    if (k == 0) begin : g_head
      assign left_slot = SLOT_EMPTY;
      assign left_ins  = 1'b0;
    end else begin : g_body
      assign left_slot = slot_w[k-1];
      assign left_ins  = ins_w[k-1];
    end

    if (k == TIMERS-1) begin : g_tail
      assign right_slot = SLOT_EMPTY;
    end else begin : g_inner
      assign right_slot = slot_w[k+1];
    end

    stq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_slot  (left_slot),
      .left_ins   (left_ins),
      .right_slot (right_slot),
      .chain_in   (chain_w[k]),
      .slot       (slot_w[k]),
      .ins        (ins_w[k]),
      .chain_out  (chain_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_map_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_map_r <= armed_map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    key_r       <= key_nxt;
    ins_ok_r    <= ins_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_which_r <= out_which_nxt;
    out_pend_r  <= out_pend_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

### hdl/stq_checker.sv
//------------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer queue
// Watches both channels and flags broken result behavior.
//------------------------------------------------------------------------------
`default_nettype none

module stq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [stq_pkg::OP_W-1:0]   in_operation,
  input logic [stq_pkg::ID_W-1:0]   in_timer_id,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [stq_pkg::KIND_W-1:0] out_kind,
  input logic [stq_pkg::ID_W-1:0]   out_which_timer,
  input logic                       out_pending,
  input logic                       out_last
);
  import stq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_which_timer) && $stable(out_pending) && $stable(out_last))
    else $error("result item changed while stalled");

  // non-tick requests answer next cycle with one final item for the same timer
  a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation != OP_TICK) |=>
      out_valid && out_last && (out_which_timer == $past(in_timer_id)))
    else $error("request not answered by one final item");

  a_query_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == OP_QUERY) |=> out_kind == KIND_STATUS)
    else $error("query answered with wrong kind");

  // a tick keeps the request side closed while it scans the head
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == OP_TICK) |=> !in_ready)
    else $error("request taken during tick");

  a_pend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_DELETE) || (out_kind == KIND_FIRED)) |->
      !out_pending)
    else $error("pending flag set on delete or fired item");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_operation    (in_ch.operation),
  .in_timer_id     (in_ch.timer_id),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_which_timer (out_ch.which_timer),
  .out_pending     (out_ch.pending),
  .out_last        (out_ch.last)
);

`default_nettype wire
